/* hw/rtl/bole_pkg.sv */
package bole_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // request actions
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_SEARCH = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_BEYOND   = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [3:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [4:0]         count;
    logic signed [31:0] read_value;
  } out_item_t;

endpackage

/* hw/rtl/bounded_ordered_list_engine.sv */
// path from accept to result: insert, append, unused actions and early misses go from idle
//   straight to the output state; read passes a RAM read state first; search and remove scan, remove may shift
// throughput: one request at a time, next accept once the result is loaded into the output
//   register; the list RAM port moves one entry per cycle in scan and shift
// reset: synchronous active-low rst_n empties the list (count and head to zero);
//   RAM contents are not cleared, entries are only read below the count
module bounded_ordered_list_engine #(
  parameter int CAPACITY   = bole_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bole_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bole_pkg::out_item_t out_data
);

  localparam int AW = $clog2(CAPACITY);      // physical RAM index
  localparam int CW = $clog2(CAPACITY + 1);  // count, holds CAPACITY itself

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // control state
  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] head_r, head_nxt;   // ring position of list front
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;

  // per-request working registers
  logic [2:0]            act_r, act_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;   // next logical index to read
  logic [CW-1:0]         wk_idx_r, wk_idx_nxt;   // index being compared or written
  logic [1:0]            status_r, status_nxt;
  logic                  found_r, found_nxt;
  logic signed [31:0]    rdv_r, rdv_nxt;
  bole_pkg::out_item_t   out_data_r, out_data_nxt;

  // ram port
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                  in_acc;
  logic                  full;
  logic                  pos_ok;
  logic [CW-1:0]         last_idx;
  logic [AW-1:0]         head_dec;
  logic [DATA_WIDTH-1:0] val_in;

  // logical list index to ring address, index is always below CAPACITY
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(idx);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return AW'(sum);
  endfunction

  bole_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (st_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stored width: sign extend or truncate the request value
  assign val_in   = DATA_WIDTH'(in_data.value);
  assign full     = (count_r == CW'(CAPACITY));
  assign last_idx = count_r - CW'(1);
  assign head_dec = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
  assign pos_ok   = (CW+4)'(in_data.position) < (CW+4)'(count_r);

  always_comb begin
    st_nxt        = st_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    act_nxt       = act_r;
    val_nxt       = val_r;
    rd_idx_nxt    = rd_idx_r;
    wk_idx_nxt    = wk_idx_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    rdv_nxt       = rdv_r;
    out_data_nxt  = out_data_r;
    // result leaves on a transfer
    out_valid_nxt = out_valid_r && out_stall;

    ram_we    = 1'b0;
    ram_waddr = phys(head_r, count_r);
    ram_wdata = val_in;
    ram_re    = 1'b0;
    ram_raddr = phys(head_r, rd_idx_r);

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt    = in_data.action;
          val_nxt    = val_in;
          status_nxt = bole_pkg::ST_DONE;
          found_nxt  = 1'b0;
          rdv_nxt    = '0;
          st_nxt     = S_OUT;
          unique case (in_data.action) inside
            bole_pkg::ACT_INSERT: begin
              // front insert: step the ring head back, no data moves
              if (full) begin
                status_nxt = bole_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = head_dec;
                head_nxt  = head_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            bole_pkg::ACT_APPEND: begin
              if (full) begin
                status_nxt = bole_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            bole_pkg::ACT_SEARCH, bole_pkg::ACT_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = bole_pkg::ST_NOTFOUND;
              end else begin
                // start the scan at the front, reads run one index ahead
                ram_re     = 1'b1;
                ram_raddr  = head_r;
                rd_idx_nxt = CW'(1);
                wk_idx_nxt = '0;
                st_nxt     = S_SCAN;
              end
            end
            bole_pkg::ACT_READ: begin
              if (!pos_ok) begin
                status_nxt = bole_pkg::ST_BEYOND;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = phys(head_r, CW'(in_data.position));
                st_nxt    = S_RD;
              end
            end
            default: begin
              // unused action codes give a plain done
            end
          endcase
        end
      end

      S_RD: begin
        rdv_nxt = 32'($signed(ram_rdata));
        st_nxt  = S_OUT;
      end

      S_SCAN: begin
        // keep the read pipe one entry ahead of the compare
        if (rd_idx_r < count_r) begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        if (ram_rdata == val_r) begin
          found_nxt = 1'b1;
          st_nxt    = S_OUT;
          if (act_r == bole_pkg::ACT_REMOVE) begin
            if (wk_idx_r == last_idx) begin
              // hit on the tail entry, nothing to move
              count_nxt = count_r - CW'(1);
            end else begin
              // entry after the hit is being read now
              st_nxt = S_SHIFT;
            end
          end
        end else if (wk_idx_r == last_idx) begin
          status_nxt = bole_pkg::ST_NOTFOUND;
          st_nxt     = S_OUT;
        end else begin
          wk_idx_nxt = wk_idx_r + CW'(1);
        end
      end

      S_SHIFT: begin
        // close the gap: entry wk+1 lands on wk, one per cycle
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, wk_idx_r);
        ram_wdata = ram_rdata;
        if (rd_idx_r < count_r) begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        wk_idx_nxt = wk_idx_r + CW'(1);
        if ((wk_idx_r + CW'(1)) == last_idx) begin
          count_nxt = count_r - CW'(1);
          st_nxt    = S_OUT;
        end
      end

      S_OUT: begin
        // load the output register once the previous result has gone
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.status     = status_r;
          out_data_nxt.found      = found_r;
          out_data_nxt.count      = 5'(count_r);
          out_data_nxt.read_value = rdv_r;
          out_valid_nxt           = 1'b1;
          st_nxt                  = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    val_r      <= val_nxt;
    rd_idx_r   <= rd_idx_nxt;
    wk_idx_r   <= wk_idx_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    rdv_r      <= rdv_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* hw/rtl/bole_ram.sv */
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* bench/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bole_pkg::*;

  // spare action codes, the block treats them as no-ops
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int LIST_CAP    = CAPACITY_DEF;
  localparam int NUM_DIR     = 28;
  localparam int PHASE_ITEMS = 256;
  // longest quiet stretch: a full-list remove plus long random
  // stall and gap runs, taken many times over
  localparam int WATCH_LIMIT = 2000;

  // one row of the directed table: request, whether a hand-typed reply is
  // given, and that reply
  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // hand-typed reply travels with the request, driven on the same edges
  logic      typed_now  = 1'b0;
  out_item_t typed_want = '0;

  int gap_pct   = 0;
  int stall_pct = 0;

  // shadow copy of the list, advanced on every accepted request
  logic signed [31:0] shadow_mem [LIST_CAP];
  int                 shadow_len = 0;

  // replies the block still owes, oldest first
  out_item_t owed_replies [$];

  int fail_count   = 0;
  int quiet_cycles = 0;
  int act_seen [8];
  int reply_total  = 0;
  int full_seen    = 0;
  int miss_seen    = 0;
  int beyond_seen  = 0;
  int peak_len     = 0;

  // directed table: empty-list corner cases, fill to capacity with extreme
  // and alternating-bit values, full-list rejects, duplicate removal
  dir_row_t dir_rows [NUM_DIR] = '{
    '{'{ACT_READ,     32'h0000_0000, 4'd0},  1'b1, '{ST_BEYOND,   1'b0, 5'd0, 32'h0}},
    '{'{ACT_SEARCH,   32'h0000_0000, 4'd0},  1'b1, '{ST_NOTFOUND, 1'b0, 5'd0, 32'h0}},
    '{'{ACT_REMOVE,   32'h7fff_ffff, 4'd0},  1'b1, '{ST_NOTFOUND, 1'b0, 5'd0, 32'h0}},
    '{'{ACT_SPARE_HI, 32'hffff_ffff, 4'd15}, 1'b1, '{ST_DONE,     1'b0, 5'd0, 32'h0}},
    '{'{ACT_INSERT,   32'h7fff_ffff, 4'd0},  1'b1, '{ST_DONE,     1'b0, 5'd1, 32'h0}},
    '{'{ACT_APPEND,   32'h8000_0000, 4'd0},  1'b1, '{ST_DONE,     1'b0, 5'd2, 32'h0}},
    '{'{ACT_INSERT,   32'h0000_0000, 4'd0},  1'b1, '{ST_DONE,     1'b0, 5'd3, 32'h0}},
    '{'{ACT_APPEND,   32'hffff_ffff, 4'd0},  1'b1, '{ST_DONE,     1'b0, 5'd4, 32'h0}},
    '{'{ACT_APPEND,   32'h7fff_ffff, 4'd0},  1'b0, '0},
    '{'{ACT_APPEND,   32'h5555_5555, 4'd0},  1'b0, '0},
    '{'{ACT_APPEND,   32'haaaa_aaaa, 4'd0},  1'b0, '0},
    '{'{ACT_APPEND,   32'h0000_0001, 4'd0},  1'b0, '0},
    '{'{ACT_APPEND,   32'h0000_0002, 4'd0},  1'b0, '0},
    '{'{ACT_APPEND,   32'h0000_0003, 4'd0},  1'b0, '0},
    '{'{ACT_APPEND,   32'h0001_0000, 4'd0},  1'b0, '0},
    '{'{ACT_APPEND,   32'h0000_ffff, 4'd0},  1'b0, '0},
    '{'{ACT_APPEND,   32'h1234_5678, 4'd0},  1'b0, '0},
    '{'{ACT_APPEND,   32'h89ab_cdef, 4'd0},  1'b0, '0},
    '{'{ACT_APPEND,   32'hffff_fffe, 4'd0},  1'b0, '0},
    '{'{ACT_APPEND,   32'h8000_0001, 4'd0},  1'b0, '0},
    '{'{ACT_INSERT,   32'h0000_002a, 4'd0},  1'b1, '{ST_FULL,     1'b0, 5'd16, 32'h0}},
    '{'{ACT_APPEND,   32'h0000_002a, 4'd0},  1'b1, '{ST_FULL,     1'b0, 5'd16, 32'h0}},
    '{'{ACT_READ,     32'h0000_0000, 4'd15}, 1'b1,
      '{ST_DONE, 1'b0, 5'd16, 32'h8000_0001}},
    '{'{ACT_READ,     32'h0000_0000, 4'd1},  1'b1,
      '{ST_DONE, 1'b0, 5'd16, 32'h7fff_ffff}},
    // first of two equal entries goes, the later copy moves up to position 3
    '{'{ACT_REMOVE,   32'h7fff_ffff, 4'd0},  1'b1, '{ST_DONE,     1'b1, 5'd15, 32'h0}},
    '{'{ACT_SEARCH,   32'h7fff_ffff, 4'd0},  1'b1, '{ST_DONE,     1'b1, 5'd15, 32'h0}},
    '{'{ACT_READ,     32'h0000_0000, 4'd3},  1'b1,
      '{ST_DONE, 1'b0, 5'd15, 32'h7fff_ffff}},
    '{'{ACT_READ,     32'h0000_0000, 4'd15}, 1'b1, '{ST_BEYOND,   1'b0, 5'd15, 32'h0}}
  };

  bounded_ordered_list_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // advance the shadow list by one request and work out the reply
  task automatic shadow_list_request(input in_item_t r, output out_item_t res);
    int i;
    int hit;
    res = '0;
    case (r.action)
      ACT_INSERT, ACT_APPEND: begin
        if (shadow_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else if (r.action == ACT_INSERT) begin
          for (i = shadow_len; i > 0; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[0] = r.value;
          shadow_len++;
        end else begin
          shadow_mem[shadow_len] = r.value;
          shadow_len++;
        end
      end
      ACT_SEARCH, ACT_REMOVE: begin
        hit = -1;
        for (i = 0; i < shadow_len; i++) begin
          if (hit < 0 && shadow_mem[i] == r.value) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.found = 1'b1;
          if (r.action == ACT_REMOVE) begin
            // close the gap left by the removed entry
            for (i = hit; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i+1];
            shadow_len--;
          end
        end
      end
      ACT_READ: begin
        if (int'(r.position) >= shadow_len) res.status = ST_BEYOND;
        else res.read_value = shadow_mem[r.position];
      end
      default: ;
    endcase
    res.count = 5'(shadow_len);
  endtask

  task automatic flag_error(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  // input and output transfer tracking share one block so the shadow list
  // and the owed replies only ever change here
  always @(posedge clk) begin : xfer_mon
    out_item_t pred;
    out_item_t want;
    logic      moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      moved = 1'b1;
      shadow_list_request(in_data, pred);
      act_seen[in_data.action]++;
      if (shadow_len > peak_len) peak_len = shadow_len;
      owed_replies.push_back(typed_now ? typed_want : pred);
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      reply_total++;
      if (out_data.status == ST_FULL) full_seen++;
      if (out_data.status == ST_NOTFOUND) miss_seen++;
      if (out_data.status == ST_BEYOND) beyond_seen++;
      if (owed_replies.size() == 0) begin
        flag_error($sformatf("%0t: reply with none owed: st=%0d fd=%0d cnt=%0d rv=%h",
                             $realtime, out_data.status, out_data.found,
                             out_data.count, out_data.read_value));
      end else begin
        want = owed_replies.pop_front();
        if (out_data.status !== want.status || out_data.found !== want.found ||
            out_data.count !== want.count || out_data.read_value !== want.read_value) begin
          flag_error($sformatf(
            "%0t: mismatch want st/fd/cnt/rv %0d/%0d/%0d/%h got %0d/%0d/%0d/%h",
            $realtime, want.status, want.found, want.count, want.read_value,
            out_data.status, out_data.found, out_data.count, out_data.read_value));
        end
      end
    end
    // watchdog: too long without any transfer means the block hung
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, WATCH_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // hold one request on the input until the transfer happens
  task automatic send_request(input in_item_t r, input logic typed, input out_item_t want);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= r;
    typed_now  <= typed;
    typed_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // values from a small set make hits and duplicates common
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(11))
      0, 1, 2, 3: return $urandom;
      4:  return 32'h8000_0000;
      5:  return 32'h7fff_ffff;
      6:  return 32'hffff_ffff;
      7:  return 32'h0000_0000;
      8:  return 32'h0000_0001;
      9:  return 32'h5a5a_a5a5;
      10: return 32'h0000_8000;
      default: return 32'(-7);
    endcase
  endfunction

  // grow_pct sets how often the request adds to the list
  function automatic in_item_t make_request(input int grow_pct);
    in_item_t r;
    int       roll;
    r.value    = pick_value();
    r.position = 4'($urandom_range(15));
    roll       = $urandom_range(99);
    if (roll < 3) begin
      r.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    end else if (roll < 3 + grow_pct) begin
      r.action = $urandom_range(1) ? ACT_INSERT : ACT_APPEND;
    end else begin
      case ($urandom_range(2))
        0:       r.action = ACT_SEARCH;
        1:       r.action = ACT_REMOVE;
        default: r.action = ACT_READ;
      endcase
      // aim most lookups at a stored entry and most reads below the count
      if (r.action != ACT_READ && shadow_len > 0 && $urandom_range(99) < 70)
        r.value = shadow_mem[$urandom_range(shadow_len - 1)];
      if (r.action == ACT_READ && shadow_len > 0 && $urandom_range(99) < 85)
        r.position = 4'($urandom_range(shadow_len - 1));
    end
    return r;
  endfunction

  // drop valid and let every owed reply come back
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_replies.size() != 0);
  endtask

  initial begin
    int       counted;
    int       spare_total;
    in_item_t req;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    for (int k = 0; k < NUM_DIR; k++)
      send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
    drain_replies();

    // random phases: none, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 58; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 58; end
        default: begin gap_pct = 36; stall_pct = 36; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        // alternate filling and draining stretches so full and empty both occur
        req = make_request(((counted / 32) % 2 == 0) ? 70 : 8);
        if (req.action <= ACT_READ) counted++;
        send_request(req, 1'b0, '0);
      end
      drain_replies();
    end

    stall_pct = 0;
    repeat (25) @(posedge clk);

    spare_total = 0;
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) spare_total += act_seen[a];
    $display("covered: insert %0d, append %0d, search %0d, remove %0d, read %0d, spare %0d",
             act_seen[ACT_INSERT], act_seen[ACT_APPEND], act_seen[ACT_SEARCH],
             act_seen[ACT_REMOVE], act_seen[ACT_READ], spare_total);
    $display("replies %0d: full %0d, miss %0d, beyond %0d, deepest %0d, errors %0d",
             reply_total, full_seen, miss_seen, beyond_seen, peak_len, fail_count);
    if (fail_count == 0 && owed_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
